// ----- rtl/epi_pkg.sv -----
// ----------------------------------------------------------------------------
// epi_pkg
// Shared constants, codes and pipeline payload types for the edge/plane
// intersection block.
// ----------------------------------------------------------------------------
package epi_pkg;

  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int T_FRAC_BITS     = 32;
  localparam int TOL_W           = 31;
  localparam int E_W             = 66;
  localparam int DEN_W           = 66;
  localparam int PROD_W          = COORD_W + T_FRAC_BITS;
  localparam int ADDR_W          = 5;

  localparam logic [2:0] REG_A   = 3'd0;
  localparam logic [2:0] REG_B   = 3'd1;
  localparam logic [2:0] REG_C   = 3'd2;
  localparam logic [2:0] REG_D   = 3'd3;
  localparam logic [2:0] REG_TOL = 3'd4;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_ON   = 2'd1;
  localparam logic [1:0] SIDE_NEG  = 2'd2;
  localparam logic [1:0] SIDE_POS  = 2'd3;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_START,
    SEL_END,
    SEL_CROSS
  } sel_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] p1;
    logic [2:0][COORD_W-1:0] p2;
    logic [1:0]              side;
    sel_t                    sel;
  } item_t;

  typedef struct packed {
    item_t                  item;
    logic [DEN_W-1:0]       rem;
    logic [DEN_W-1:0]       den;
    logic [T_FRAC_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    logic [COORD_W-1:0] a;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] d;
    logic [TOL_W-1:0]   tol;
  } plane_t;

  typedef struct packed {
    logic [1:0]              side;
    logic [2:0][COORD_W-1:0] point;
  } result_t;

endpackage

// ----- rtl/epi_dist.sv -----
// ----------------------------------------------------------------------------
// epi_dist
// Front stages: capture the edge, form the six products, sum the two plane
// distances, classify both endpoints and set up the divider operands.
// ----------------------------------------------------------------------------
module epi_dist (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [6*epi_pkg::COORD_W-1:0] in_data,
  input  epi_pkg::plane_t         plane,
  output logic                    out_valid,
  output epi_pkg::div_t           out_div
);
  import epi_pkg::*;

  logic                              v0_r, v1_r, v2_r, v3_r;
  item_t                             it0_r, it1_r, it2_r;
  logic signed [2*COORD_W-1:0]       m1_r [3];
  logic signed [2*COORD_W-1:0]       m2_r [3];
  logic signed [E_W-1:0]             e1_r, e2_r;
  logic signed [E_W-1:0]             e1_nxt, e2_nxt, dsc, tol_s;
  logic signed [E_W:0]               diff;
  logic [1:0]                        s1, s2;
  div_t                              div_nxt, div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        it0_r.p1[k] <= in_data[k*COORD_W +: COORD_W];
        it0_r.p2[k] <= in_data[(k+3)*COORD_W +: COORD_W];
      end
      it0_r.side <= SIDE_NONE;
      it0_r.sel  <= SEL_ZERO;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r   <= it0_r;
      m1_r[0] <= $signed(plane.a) * $signed(it0_r.p1[0]);
      m1_r[1] <= $signed(plane.b) * $signed(it0_r.p1[1]);
      m1_r[2] <= $signed(plane.c) * $signed(it0_r.p1[2]);
      m2_r[0] <= $signed(plane.a) * $signed(it0_r.p2[0]);
      m2_r[1] <= $signed(plane.b) * $signed(it0_r.p2[1]);
      m2_r[2] <= $signed(plane.c) * $signed(it0_r.p2[2]);
    end
  end

  // distances
  always_comb begin
    dsc    = E_W'($signed(plane.d)) <<< COORD_FRAC_BITS;
    e1_nxt = E_W'(m1_r[0]) + E_W'(m1_r[1]) + E_W'(m1_r[2]) + dsc;
    e2_nxt = E_W'(m2_r[0]) + E_W'(m2_r[1]) + E_W'(m2_r[2]) + dsc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r <= it1_r;
      e1_r  <= e1_nxt;
      e2_r  <= e2_nxt;
    end
  end

  // classify and set up the divide
  always_comb begin
    tol_s = $signed(E_W'({plane.tol, {COORD_FRAC_BITS{1'b0}}}));
    s1 = (e1_r < -tol_s) ? SIDE_NEG : ((e1_r > tol_s) ? SIDE_POS : SIDE_NONE);
    s2 = (e2_r < -tol_s) ? SIDE_NEG : ((e2_r > tol_s) ? SIDE_POS : SIDE_NONE);
    diff = (E_W+1)'(e2_r) - (E_W+1)'(e1_r);
    div_nxt      = '0;
    div_nxt.item = it2_r;
    div_nxt.rem  = e1_r[E_W-1] ? DEN_W'(-e1_r) : DEN_W'(e1_r);
    div_nxt.den  = diff[E_W] ? DEN_W'(-diff) : DEN_W'(diff);
    if (s1 == SIDE_NONE) begin
      div_nxt.item.side = SIDE_ON;
      div_nxt.item.sel  = SEL_START;
    end else if (s2 == SIDE_NONE) begin
      div_nxt.item.side = s1;
      div_nxt.item.sel  = SEL_END;
    end else if (s1 != s2) begin
      div_nxt.item.side = s1;
      div_nxt.item.sel  = SEL_CROSS;
    end else begin
      div_nxt.item.side = SIDE_NONE;
      div_nxt.item.sel  = SEL_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_div   = div_r;

endmodule

// ----- rtl/epi_div.sv -----
// ----------------------------------------------------------------------------
// epi_div
// Restoring divider, one quotient bit per stage, forming t = |e1|/|e2-e1|
// as an unsigned fraction.
// ----------------------------------------------------------------------------
module epi_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  epi_pkg::div_t in_div,
  output logic          out_valid,
  output epi_pkg::div_t out_div
);
  import epi_pkg::*;

  logic v_r  [T_FRAC_BITS];
  div_t st_r [T_FRAC_BITS];

  for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_step
    logic           cur_v;
    div_t           cur;
    logic [DEN_W:0] r2;
    logic           ge;
    div_t           nxt;

    if (i == 0) begin : g_head
      assign cur_v = in_valid;
      assign cur   = in_div;
    end else begin : g_body
      assign cur_v = v_r[i-1];
      assign cur   = st_r[i-1];
    end

    always_comb begin
      r2  = {cur.rem, 1'b0};
      ge  = r2 >= {1'b0, cur.den};
      nxt = cur;
      nxt.rem = ge ? DEN_W'(r2 - {1'b0, cur.den}) : DEN_W'(r2);
      nxt.q   = {cur.q[T_FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= nxt;
      end
    end
  end

  assign out_valid = v_r[T_FRAC_BITS-1];
  assign out_div   = st_r[T_FRAC_BITS-1];

endmodule

// ----- rtl/epi_interp.sv -----
// ----------------------------------------------------------------------------
// epi_interp
// Back stages: scale each axis delta by t, round, add to the start point and
// select the reported point.
// ----------------------------------------------------------------------------
module epi_interp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  epi_pkg::div_t   in_div,
  output logic            out_valid,
  output epi_pkg::result_t out_res
);
  import epi_pkg::*;

  logic                    v0_r, v1_r;
  item_t                   it_r;
  logic [PROD_W-1:0]       prod_r [3];
  logic [2:0]              neg_r;
  logic signed [COORD_W:0] dx [3];
  logic [COORD_W-1:0]      mag [3];
  logic [PROD_W:0]         rnd [3];
  logic [COORD_W-1:0]      off [3];
  result_t                 res_nxt, res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k]  = (COORD_W+1)'($signed(in_div.item.p2[k]))
             - (COORD_W+1)'($signed(in_div.item.p1[k]));
      mag[k] = dx[k][COORD_W] ? COORD_W'(-dx[k]) : COORD_W'(dx[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r <= in_div.item;
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PROD_W'(mag[k]) * PROD_W'(in_div.q);
        neg_r[k]  <= dx[k][COORD_W];
      end
    end
  end

  always_comb begin
    res_nxt.side = it_r.side;
    for (int k = 0; k < 3; k++) begin
      rnd[k] = (PROD_W+1)'(prod_r[k]) + ((PROD_W+1)'(1) << (T_FRAC_BITS - 1));
      off[k] = COORD_W'(rnd[k] >> T_FRAC_BITS);
      case (it_r.sel)
        SEL_START: res_nxt.point[k] = it_r.p1[k];
        SEL_END:   res_nxt.point[k] = it_r.p2[k];
        SEL_CROSS: res_nxt.point[k] = neg_r[k] ? it_r.p1[k] - off[k]
                                               : it_r.p1[k] + off[k];
        default:   res_nxt.point[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = v1_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/edge_plane_intersection_top.sv -----
// ----------------------------------------------------------------------------
// edge_plane_intersection_top
// Tests a stream of edges against a configured plane and reports the
// touching or crossing point of each edge.
//
// in_* stream: one edge per request, six signed Q16.16 coordinates in
// in_tdata. out_* stream: one result per edge, the three point coordinates
// in out_tdata and the side code in out_tuser. The plane a, b, c, d and the
// tolerance are written over the APB port at byte addresses 0, 4, 8, 12, 16
// while no edge is in flight; reads return the register values.
// Throughput is one edge per cycle while the skid register is empty. The
// pipeline has four distance stages, 32 divider stages (one quotient bit
// each), two interpolation stages and the output register.
// A synchronous reset empties the pipeline and loads a, b, c, d with zero
// and the tolerance with 66. When the receiver stalls, the result moves into
// a one-entry skid register; the pipeline then holds and in_tready drops
// until the skid register drains. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module edge_plane_intersection_top (
  input  logic                     clk,
  input  logic                     rst_n,
  // start_x, start_y, start_z, end_x, end_y, end_z, 32 bits each
  input  logic [6*epi_pkg::COORD_W-1:0] in_tdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // point_x, point_y, point_z, 32 bits each
  output logic [3*epi_pkg::COORD_W-1:0] out_tdata,
  // side
  output logic [1:0]               out_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [epi_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import epi_pkg::*;

  plane_t  plane_r;
  logic    en;
  logic    dv, qv, rv;
  div_t    dd, qd;
  result_t rr, out_r, skid_r;
  logic    ov_r, sv_r, pop;
  logic    wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.a   <= '0;
      plane_r.b   <= '0;
      plane_r.c   <= '0;
      plane_r.d   <= '0;
      plane_r.tol <= TOL_RESET;
    end else if (wr) begin
      case (cfg_paddr[4:2])
        REG_A:   plane_r.a   <= cfg_pwdata;
        REG_B:   plane_r.b   <= cfg_pwdata;
        REG_C:   plane_r.c   <= cfg_pwdata;
        REG_D:   plane_r.d   <= cfg_pwdata;
        REG_TOL: plane_r.tol <= cfg_pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_A:   cfg_prdata = plane_r.a;
      REG_B:   cfg_prdata = plane_r.b;
      REG_C:   cfg_prdata = plane_r.c;
      REG_D:   cfg_prdata = plane_r.d;
      REG_TOL: cfg_prdata = {1'b0, plane_r.tol};
      default: cfg_prdata = '0;
    endcase
  end

  assign en        = ~sv_r;
  assign in_tready = en;

  epi_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .plane     (plane_r),
    .out_valid (dv),
    .out_div   (dd)
  );

  epi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv),
    .in_div    (dd),
    .out_valid (qv),
    .out_div   (qd)
  );

  epi_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (qv),
    .in_div    (qd),
    .out_valid (rv),
    .out_res   (rr)
  );

  assign pop = ov_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (pop) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end
    end else if (!ov_r || pop) begin
      ov_r <= rv;
    end else if (rv) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (!ov_r || pop) begin
      out_r <= rr;
    end else begin
      skid_r <= rr;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = out_r.side;
  assign out_tdata  = {out_r.point[2], out_r.point[1], out_r.point[0]};

endmodule

// ----- tb/sv/edge_plane_intersection_checker.sv -----
// ----------------------------------------------------------------------------
// edge_plane_intersection_checker
// Watches the edge and result streams, computes the expected touching or
// crossing point of every accepted edge and compares each result with it.
// ----------------------------------------------------------------------------
module edge_plane_intersection_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [6*epi_pkg::COORD_W-1:0] in_tdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [3*epi_pkg::COORD_W-1:0] out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [epi_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  input  logic                          cfg_pready,
  output int                            errors,
  output int                            pending
);
  import epi_pkg::*;

  typedef struct {
    logic [1:0]  side;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } hit_t;

  logic signed [31:0] na, nb, nc, nd;
  logic [30:0]        tol;
  hit_t               hits_due[$];

  assign pending = hits_due.size();

  function automatic logic signed [127:0] plane_dist(logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z);
    logic signed [127:0] e;
    e = 128'(na) * 128'(x) + 128'(nb) * 128'(y) + 128'(nc) * 128'(z)
        + (128'(nd) <<< COORD_FRAC_BITS);
    return e;
  endfunction

  function automatic logic [1:0] side_of(logic signed [127:0] e);
    logic signed [127:0] t;
    t = 128'($signed({1'b0, tol})) <<< COORD_FRAC_BITS;
    if (e < -t) return SIDE_NEG;
    if (e > t) return SIDE_POS;
    return SIDE_ON;
  endfunction

  function automatic logic [31:0] lerp(logic signed [31:0] p1, logic signed [31:0] p2,
                                       logic [127:0] t);
    logic signed [63:0] dx;
    logic [63:0]        mag;
    logic [127:0]       off;
    dx  = 64'(p2) - 64'(p1);
    mag = dx < 0 ? 64'(-dx) : 64'(dx);
    off = (128'(mag) * t + (128'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
    return dx < 0 ? 32'(64'(p1) - 64'(off)) : 32'(64'(p1) + 64'(off));
  endfunction

  function automatic hit_t predict_hit(logic [191:0] d);
    hit_t                r;
    logic signed [31:0]  p[6];
    logic signed [127:0] e1, e2, a1, dn;
    logic [1:0]          s1, s2;
    logic [127:0]        t;
    for (int k = 0; k < 6; k++) p[k] = d[32*k +: 32];
    r  = '{SIDE_NONE, 0, 0, 0};
    e1 = plane_dist(p[0], p[1], p[2]);
    s1 = side_of(e1);
    if (s1 == SIDE_ON) begin
      r = '{SIDE_ON, p[0], p[1], p[2]};
    end else begin
      e2 = plane_dist(p[3], p[4], p[5]);
      s2 = side_of(e2);
      if (s2 == SIDE_ON) begin
        r = '{s1, p[3], p[4], p[5]};
      end else if (s1 != s2) begin
        a1 = e1 < 0 ? -e1 : e1;
        dn = e2 - e1;
        if (dn < 0) dn = -dn;
        t = (128'(a1) << T_FRAC_BITS) / 128'(dn);
        r = '{s1, lerp(p[0], p[3], t), lerp(p[1], p[4], t), lerp(p[2], p[5], t)};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hit_t h;
    int   bad;
    bad = 0;
    if (!rst_n) begin
      na <= 0; nb <= 0; nc <= 0; nd <= 0; tol <= 31'd66;
      errors <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_A:   na  <= cfg_pwdata;
          REG_B:   nb  <= cfg_pwdata;
          REG_C:   nc  <= cfg_pwdata;
          REG_D:   nd  <= cfg_pwdata;
          REG_TOL: tol <= cfg_pwdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) hits_due = {hits_due, predict_hit(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (hits_due.size() == 0) begin
          $error("unexpected result side=%0d", out_tuser);
          bad = bad + 1;
        end else begin
          h = hits_due.pop_front();
          if (out_tuser !== h.side) begin
            $error("side expected %0d actual %0d", h.side, out_tuser);
            bad = bad + 1;
          end
          if (out_tdata[31:0] !== h.px) begin
            $error("point_x expected %h actual %h", h.px, out_tdata[31:0]);
            bad = bad + 1;
          end
          if (out_tdata[63:32] !== h.py) begin
            $error("point_y expected %h actual %h", h.py, out_tdata[63:32]);
            bad = bad + 1;
          end
          if (out_tdata[95:64] !== h.pz) begin
            $error("point_z expected %h actual %h", h.pz, out_tdata[95:64]);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

// ----- tb/sv/edge_plane_intersection_top_tb.sv -----
// ----------------------------------------------------------------------------
// edge_plane_intersection_top_tb
// Streams directed and random edges through the block under several plane
// settings and idle and stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module edge_plane_intersection_top_tb;
  import epi_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic [191:0] in_tdata = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  int           errors, pending;
  int           send_idle = 0, recv_stall = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  edge_plane_intersection_top i_dut (.*);

  edge_plane_intersection_checker i_chk (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= ADDR_W'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [31:0] t);
    drain();
    write_reg(REG_A, a); write_reg(REG_B, b); write_reg(REG_C, c);
    write_reg(REG_D, d); write_reg(REG_TOL, t);
  endtask

  task automatic send_edge(logic [191:0] d);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2000000)) - 1000000;
      default: return $signed($urandom_range(200)) - 100 << 16;
    endcase
  endfunction

  function automatic logic [191:0] rand_edge(int mode);
    logic [191:0] d;
    for (int k = 0; k < 6; k++) d[32*k +: 32] = coord(mode);
    return d;
  endfunction

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    send_edge({6{32'h7fff_ffff}});
    send_edge({6{32'h8000_0000}});
    set_plane(32'h1_0000, 0, 0, 0, 0);
    send_edge({32'd0, 32'd0, 32'h5_0000, 32'd0, 32'd0, 32'hfffb_0000});
    send_edge({32'd0, 32'd0, 32'hfffb_0000, 32'd0, 32'd0, 32'h5_0000});
    send_edge({32'd0, 32'd0, 32'h5_0000, 32'd0, 32'd0, 32'h1_0000});
    send_edge({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h1_0000});
    send_edge({32'd0, 32'd0, 32'h0, 32'd0, 32'd0, 32'h7fff_ffff});
    send_edge({32'd3, 32'd2, 32'h7fff_ffff, 32'd1, 32'd9, 32'h8000_0000});
    send_edge({32'd3, 32'd2, 32'h8000_0000, 32'd1, 32'd9, 32'h7fff_ffff});
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    for (int i = 0; i < 16; i++)
      send_edge({ext[i%4], ext[(i/4)%4], ext[i%3], ext[(i+1)%4], ext[(i+2)%4], ext[i%2]});
    set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'h7fff_ffff, 0);
    for (int i = 0; i < 8; i++) send_edge(rand_edge(0));
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 83; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 83; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      set_plane($urandom_range(1) ? $urandom : coord(2), coord(2), coord(1),
                coord($urandom_range(2)), ph == 7 ? 0 : $urandom_range(3) == 0 ?
                $urandom : $urandom_range(1 << $urandom_range(30)));
      for (int i = 0; i < 240; i++) begin
        send_edge(rand_edge(i % 3));
        if (i == 120 && ph == 3) drain();
      end
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
